@@ hdl/gcs_pkg.sv @@
// ----------------------------------------------------------------------------
// gcs_pkg
// Shared constants and types of the streaming 3x3 grey-level convolution core.
// ----------------------------------------------------------------------------
package gcs_pkg;

  localparam int PIX_W       = 8;
  localparam int PIX_MAX     = 255;
  localparam int CNT_W       = 10;
  localparam int DIM_W       = 11;
  localparam int KREG_W      = 36;
  localparam int CFG_IDX_W   = 3;
  localparam int KERNEL_SIZE = 3;
  localparam int NUM_TAPS    = KERNEL_SIZE * KERNEL_SIZE;
  localparam int FRAC_BITS   = 8;
  localparam int FRAME_MAX   = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

  typedef logic [PIX_W-1:0] pix_t;

  typedef logic [KERNEL_SIZE-1:0][KREG_W-1:0] kernel_t;

  // Last column and last row index of the frame after clamping.
  typedef struct packed {
    logic [CNT_W-1:0] last_col;
    logic [CNT_W-1:0] last_row;
  } geom_t;

  // Position and flags that travel with one result item.
  typedef struct packed {
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic             done;
    logic             last;
  } meta_t;

  // One 3x3 neighborhood, tap index is kernel_row * 3 + kernel_column.
  typedef struct packed {
    pix_t [NUM_TAPS-1:0] taps;
    meta_t               meta;
  } op_t;

endpackage

@@ hdl/gcs_ram.sv @@
// ----------------------------------------------------------------------------
// gcs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/gcs_window.sv @@
// ----------------------------------------------------------------------------
// gcs_window
// Raster counters, two-line buffer, 3x3 pixel window and the result
// sequencer that hands out up to four neighborhoods per input item.
// ----------------------------------------------------------------------------
module gcs_window #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [gcs_pkg::PIX_W-1:0]   in_pixel,
  input  gcs_pkg::geom_t              geom,
  output logic                        op_valid,
  input  logic                        op_ready,
  output gcs_pkg::op_t                op
);
  import gcs_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int LW = 2 * PIX_W;

  // Result slots of one item, in the order they leave.
  localparam int SEQ_ABOVE_PREV = 0;
  localparam int SEQ_ABOVE_END  = 1;
  localparam int SEQ_OWN_PREV   = 2;
  localparam int SEQ_OWN_END    = 3;

  logic [CNT_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic             end_col, last_row, accept;
  logic [31:0]      idx_full;
  logic [AW-1:0]    rd_addr;

  logic             s1_v_r, s1_v_nxt;
  pix_t             s1_pix_r;
  logic [CNT_W-1:0] s1_col_r, s1_row_r;
  logic             s1_end_r, s1_lrow_r;
  logic [AW-1:0]    s1_addr_r;

  logic [LW-1:0]    ram_rdata;
  pix_t             two_above, above;
  logic             s1_adv, issue, has_r, has_c;

  logic [3:0]       mask_r, mask_nxt, mask_new, sel;
  logic [CNT_W-1:0] p2_col_r, p2_row_r;
  logic             p2_c1_r, p2_r1_r;
  logic [2:0][2:0][PIX_W-1:0] win_r;

  logic             own, endc;
  logic [2:0][PIX_W-1:0] rt, rm, rb, ct, cm, cb;

  function automatic logic [2:0][PIX_W-1:0] pick_cols(
    input logic [2:0][PIX_W-1:0] v,
    input logic                  endc_i,
    input logic                  c1_i
  );
    logic [2:0][PIX_W-1:0] o;
    // At the right edge the missing column mirrors onto the one to the left.
    // At column one the missing left column mirrors onto column one itself.
    o[0] = endc_i ? v[1] : (c1_i ? v[2] : v[0]);
    o[1] = endc_i ? v[2] : v[1];
    o[2] = endc_i ? v[1] : v[2];
    return o;
  endfunction

  // ---------------------------------------------------------------- input side
  assign end_col  = (col_r >= geom.last_col);
  assign last_row = (row_r >= geom.last_row);
  assign accept   = in_valid && in_ready;
  assign in_ready = !s1_v_r || s1_adv;

  assign idx_full = (32'(col_r) < 32'(MAX_WIDTH)) ? 32'(col_r) : 32'(MAX_WIDTH - 1);
  assign rd_addr  = idx_full[AW-1:0];

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (end_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_pixel;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_end_r  <= end_col;
      s1_lrow_r <= last_row;
      s1_addr_r <= rd_addr;
    end
  end

  // The upper byte holds the row two above, the lower byte the row above.
  // Each column is read when its item is taken and rewritten when the item
  // moves into the window, so the two rows shift down by one.
  gcs_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr_r),
    .wdata ({above, s1_pix_r}),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign two_above = ram_rdata[LW-1:PIX_W];
  assign above     = ram_rdata[PIX_W-1:0];

  // ---------------------------------------------------------------- sequencer
  assign has_r = (s1_row_r != '0);
  assign has_c = (s1_col_r != '0);

  always_comb begin
    mask_new                 = '0;
    mask_new[SEQ_ABOVE_PREV] = has_r && has_c;
    mask_new[SEQ_ABOVE_END]  = has_r && s1_end_r;
    mask_new[SEQ_OWN_PREV]   = has_r && s1_lrow_r && has_c;
    mask_new[SEQ_OWN_END]    = has_r && s1_lrow_r && s1_end_r;
  end

  assign sel      = mask_r & (~mask_r + 4'd1);
  assign op_valid = (mask_r != '0);
  assign issue    = op_valid && op_ready;
  // The window may shift once the current item has handed out its last result.
  assign s1_adv   = s1_v_r && ((mask_r == '0) || (op_ready && (mask_r == sel)));

  always_comb begin
    mask_nxt = mask_r;
    if (s1_adv) begin
      mask_nxt = mask_new;
    end else if (issue) begin
      mask_nxt = mask_r & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      win_r  <= '0;
    end else begin
      mask_r <= mask_nxt;
      if (s1_adv) begin
        for (int i = 0; i < 3; i++) begin
          win_r[i][0] <= win_r[i][1];
          win_r[i][1] <= win_r[i][2];
        end
        win_r[0][2] <= two_above;
        win_r[1][2] <= above;
        win_r[2][2] <= s1_pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      p2_col_r <= s1_col_r;
      p2_row_r <= s1_row_r;
      p2_c1_r  <= (s1_col_r == CNT_W'(1));
      p2_r1_r  <= (s1_row_r == CNT_W'(1));
    end
  end

  // Results for the row above use rows (two above, above, current); the top
  // row mirrors onto the current row. Results for the last row itself mirror
  // the row above below it.
  assign own  = sel[SEQ_OWN_PREV] || sel[SEQ_OWN_END];
  assign endc = sel[SEQ_ABOVE_END] || sel[SEQ_OWN_END];

  assign rt = own ? win_r[1] : (p2_r1_r ? win_r[2] : win_r[0]);
  assign rm = own ? win_r[2] : win_r[1];
  assign rb = own ? win_r[1] : win_r[2];

  assign ct = pick_cols(rt, endc, p2_c1_r);
  assign cm = pick_cols(rm, endc, p2_c1_r);
  assign cb = pick_cols(rb, endc, p2_c1_r);

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      op.taps[x]     = ct[x];
      op.taps[3 + x] = cm[x];
      op.taps[6 + x] = cb[x];
    end
    op.meta.row  = own ? p2_row_r : p2_row_r - CNT_W'(1);
    op.meta.col  = endc ? p2_col_r : p2_col_r - CNT_W'(1);
    op.meta.done = sel[SEQ_OWN_END];
    op.meta.last = (mask_r == sel);
  end

endmodule

@@ hdl/gcs_conv.sv @@
// ----------------------------------------------------------------------------
// gcs_conv
// Multiply-accumulate pipeline: nine parallel products, a sum, then rounding
// to nearest even and clamping into the output register.
// ----------------------------------------------------------------------------
module gcs_conv #(
  parameter int COEF_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       op_valid,
  output logic                       op_ready,
  input  gcs_pkg::op_t               op,
  input  gcs_pkg::kernel_t           kernel,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [gcs_pkg::PIX_W-1:0]  out_pixel,
  output gcs_pkg::meta_t             out_meta
);
  import gcs_pkg::*;

  localparam int KW = KERNEL_SIZE * COEF_BITS;
  localparam int PW = COEF_BITS + PIX_W + 1;
  localparam int SW = PW + 4;
  localparam int QW = SW - FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};

  logic [KERNEL_SIZE-1:0][KW-1:0]  kext;
  logic signed [COEF_BITS-1:0]     coef [NUM_TAPS];

  logic                 c1_v_r, c2_v_r, c3_v_r, out_v_r;
  logic                 c1_rdy, c2_rdy, c3_rdy, o_rdy;
  op_t                  c1_op_r;
  logic signed [PW-1:0] prod_nxt [NUM_TAPS];
  logic signed [PW-1:0] c2_prod_r [NUM_TAPS];
  meta_t                c2_meta_r, c3_meta_r, out_meta_r;
  logic signed [SW-1:0] sum_nxt, c3_sum_r;
  logic [QW-1:0]        q;
  logic [FRAC_BITS-1:0] rem;
  logic [QW:0]          q_rnd;
  logic                 rnd_up, positive;
  pix_t                 pix_nxt, out_pix_r;

  // Taps that lie beyond the register width read as zero.
  always_comb begin
    for (int y = 0; y < KERNEL_SIZE; y++) begin
      kext[y] = KW'(kernel[y]);
      for (int x = 0; x < KERNEL_SIZE; x++) begin
        coef[y * KERNEL_SIZE + x] = $signed(kext[y][x * COEF_BITS +: COEF_BITS]);
      end
    end
  end

  assign o_rdy    = !out_v_r || out_ready;
  assign c3_rdy   = !c3_v_r || o_rdy;
  assign c2_rdy   = !c2_v_r || c3_rdy;
  assign c1_rdy   = !c1_v_r || c2_rdy;
  assign op_ready = c1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r  <= 1'b0;
      c2_v_r  <= 1'b0;
      c3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (c1_rdy) begin
        c1_v_r <= op_valid;
      end
      if (c2_rdy) begin
        c2_v_r <= c1_v_r;
      end
      if (c3_rdy) begin
        c3_v_r <= c2_v_r;
      end
      if (o_rdy) begin
        out_v_r <= c3_v_r;
      end
    end
  end

  // Products
  always_comb begin
    for (int k = 0; k < NUM_TAPS; k++) begin
      prod_nxt[k] = coef[k] * $signed({1'b0, c1_op_r.taps[k]});
    end
  end

  // Exact sum of the nine products
  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < NUM_TAPS; k++) begin
      sum_nxt = sum_nxt + SW'(c2_prod_r[k]);
    end
  end

  // Round half to even, then clamp to the pixel range.
  assign q        = c3_sum_r[SW-1:FRAC_BITS];
  assign rem      = c3_sum_r[FRAC_BITS-1:0];
  assign positive = !c3_sum_r[SW-1] && (c3_sum_r != '0);
  assign rnd_up   = (rem > HALF) || ((rem == HALF) && q[0]);
  assign q_rnd    = {1'b0, q} + (QW + 1)'(rnd_up);

  always_comb begin
    if (!positive) begin
      pix_nxt = '0;
    end else if (q_rnd > (QW + 1)'(PIX_MAX)) begin
      pix_nxt = PIX_W'(PIX_MAX);
    end else begin
      pix_nxt = q_rnd[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (c1_rdy && op_valid) begin
      c1_op_r <= op;
    end
    if (c2_rdy && c1_v_r) begin
      c2_prod_r <= prod_nxt;
      c2_meta_r <= c1_op_r.meta;
    end
    if (c3_rdy && c2_v_r) begin
      c3_sum_r  <= sum_nxt;
      c3_meta_r <= c2_meta_r;
    end
    if (o_rdy && c3_v_r) begin
      out_pix_r  <= pix_nxt;
      out_meta_r <= c3_meta_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_pixel = out_pix_r;
  assign out_meta  = out_meta_r;

endmodule

@@ hdl/grayscale_conv3x3_stream_core.sv @@
// ----------------------------------------------------------------------------
// grayscale_conv3x3_stream_core
// Streaming 3x3 convolution of grey frames with mirrored borders.
// Path: input register, window, then operand, product, sum and output registers.
// Throughput: one item per cycle unless the output stalls; the single
// multiply-accumulate pipeline takes one neighborhood a cycle, so an item with
// several results (up to 4, at row ends and on the last row) holds the input.
// Reset: counters, pipeline, window and registers return to defaults; the
// line buffer RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module grayscale_conv3x3_stream_core #(
  parameter int MAX_WIDTH = 1024,
  parameter int COEF_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gcs_pkg::PIX_W-1:0]         in_pixel_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gcs_pkg::PIX_W-1:0]         out_pixel_out,
  output logic [gcs_pkg::CNT_W-1:0]         out_row,
  output logic [gcs_pkg::CNT_W-1:0]         out_column,
  output logic                              out_frame_done,
  output logic                              out_run_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gcs_pkg::KREG_W-1:0]        cfg_data
);
  import gcs_pkg::*;

  localparam int WLIM = (MAX_WIDTH < FRAME_MAX) ? MAX_WIDTH : FRAME_MAX;
  localparam logic [KREG_W-1:0] KMID_RST = KREG_W'(64'd1 << (FRAC_BITS + COEF_BITS));

  logic [DIM_W-1:0] frame_width_r, frame_height_r, width_cl, height_cl;
  kernel_t          kernel_r;
  geom_t            geom;
  logic             op_valid, op_ready;
  op_t              op;
  meta_t            out_meta;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= DIM_W'(FRAME_MAX);
      frame_height_r <= DIM_W'(FRAME_MAX);
      kernel_r[0]    <= '0;
      kernel_r[1]    <= KMID_RST;
      kernel_r[2]    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:   frame_width_r  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT:  frame_height_r <= cfg_data[DIM_W-1:0];
        REG_KERNEL_TOP:    kernel_r[0]    <= cfg_data;
        REG_KERNEL_MIDDLE: kernel_r[1]    <= cfg_data;
        REG_KERNEL_BOTTOM: kernel_r[2]    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Dimensions are saturated to the supported range.
  always_comb begin
    priority if (frame_width_r > DIM_W'(WLIM)) begin
      width_cl = DIM_W'(WLIM);
    end else if (frame_width_r < DIM_W'(2)) begin
      width_cl = DIM_W'(2);
    end else begin
      width_cl = frame_width_r;
    end
    priority if (frame_height_r > DIM_W'(FRAME_MAX)) begin
      height_cl = DIM_W'(FRAME_MAX);
    end else if (frame_height_r < DIM_W'(2)) begin
      height_cl = DIM_W'(2);
    end else begin
      height_cl = frame_height_r;
    end
    geom.last_col = CNT_W'(width_cl - DIM_W'(1));
    geom.last_row = CNT_W'(height_cl - DIM_W'(1));
  end

  gcs_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pixel (in_pixel_in),
    .geom     (geom),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op)
  );

  gcs_conv #(
    .COEF_BITS (COEF_BITS)
  ) u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .kernel    (kernel_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pixel (out_pixel_out),
    .out_meta  (out_meta)
  );

  assign out_row        = out_meta.row;
  assign out_column     = out_meta.col;
  assign out_frame_done = out_meta.done;
  assign out_run_last   = out_meta.last;

  // The frame's final result is always the last one of its input item.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_run_last)
    else $error("frame end result is not the last result of its item");

  // The frame ends on the bottom row, which is never row zero.
  a_done_not_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_row != '0)
    else $error("frame end reported on the top row");

  // No result is presented in the first cycle out of reset.
  a_idle_after_reset: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

@@ verif/grayscale_conv3x3_stream_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grayscale_conv3x3_stream_core_tb
// Streams whole grey frames through the 3x3 convolution core and checks every
// result item against an in-bench predictor of the line stores, the window and
// the rounding. Frame geometry and kernels are rewritten between frames.
// ----------------------------------------------------------------------------
module grayscale_conv3x3_stream_core_tb;
  import gcs_pkg::*;

  localparam int MAX_WIDTH         = 1024;
  localparam int COEF_BITS         = 12;
  localparam int WIDTH_CAP         = (MAX_WIDTH < FRAME_MAX) ? MAX_WIDTH : FRAME_MAX;
  localparam int NUM_REGS          = 5;
  localparam int RANDOM_ITEMS      = 420;
  localparam int DRAIN_CYCLES      = 12;
  localparam int LONG_HOLD         = 500;
  localparam int LONG_HOLD_TRIGGER = 16;
  localparam int IDLE_LIMIT        = 5000;

  typedef enum {PIX_RANDOM, PIX_EXTREME, PIX_FLAT} pix_kind_t;
  typedef enum {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] column;
    logic             done;
    logic             last;
  } conv_result_t;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel_in    = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [PIX_W-1:0]     out_pixel_out;
  logic [CNT_W-1:0]     out_row;
  logic [CNT_W-1:0]     out_column;
  logic                 out_frame_done;
  logic                 out_run_last;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [KREG_W-1:0]    cfg_data       = '0;

  // Predictor copy of the registers and of the datapath state.
  logic [DIM_W-1:0]  width_reg  = DIM_W'(FRAME_MAX);
  logic [DIM_W-1:0]  height_reg = DIM_W'(FRAME_MAX);
  logic [KREG_W-1:0] kernel_reg [KERNEL_SIZE] =
    '{'0, KREG_W'(1 << (FRAC_BITS + COEF_BITS)), '0};
  pix_t row_above_mem     [MAX_WIDTH] = '{default: '0};
  pix_t row_two_above_mem [MAX_WIDTH] = '{default: '0};
  pix_t window_pix [3][4]             = '{default: '0};
  int   col_count = 0;
  int   row_count = 0;

  pix_t         pending_pixels [$];
  conv_result_t expected_conv [$];
  int           error_count = 0;

  int       burst_left     = 1;
  int       gap_left       = 0;
  int       hold_left      = 0;
  bit       long_hold_done = 1'b0;
  rx_mode_t stall_mode     = RX_OPEN;
  int       mode_left      = 0;
  int       stall_phase    = 0;
  int       idle_cycles    = 0;

  grayscale_conv3x3_stream_core #(
    .MAX_WIDTH(MAX_WIDTH),
    .COEF_BITS(COEF_BITS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_row       (out_row),
    .out_column    (out_column),
    .out_frame_done(out_frame_done),
    .out_run_last  (out_run_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int clamp_dim(logic [DIM_W-1:0] raw, int upper);
    if (raw > upper) return upper;
    if (raw < 2) return 2;
    return int'(raw);
  endfunction

  function automatic logic [KREG_W-1:0] tap_row(int left, int mid, int right);
    logic [KREG_W-1:0] packed_taps;
    int taps [3];
    taps = '{left, mid, right};
    packed_taps = '0;
    for (int k = 0; k < 3; k++) packed_taps[k*COEF_BITS +: COEF_BITS] = taps[k][COEF_BITS-1:0];
    return packed_taps;
  endfunction

  function automatic logic [KREG_W-1:0] random_kernel_row();
    logic [63:0] raw_bits;
    int lo;
    int hi;
    raw_bits = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return raw_bits[KREG_W-1:0];
      1: begin
        lo = -80;
        hi = 120;
      end
      2: begin
        lo = 0;
        hi = 90;
      end
      default: begin
        lo = -300;
        hi = 300;
      end
    endcase
    return tap_row(lo + $urandom_range(0, hi - lo), lo + $urandom_range(0, hi - lo),
                   lo + $urandom_range(0, hi - lo));
  endfunction

  // Weighted sum over the window; s* pick window rows per kernel row, c* pick
  // window columns for the left, middle and right taps.
  function automatic conv_result_t window_result(int s0, int s1, int s2, int cl, int cm,
                                                 int cr, int row, int col, bit done);
    int src [3];
    int cols [3];
    longint acc;
    longint q;
    longint rem;
    conv_result_t res;
    src  = '{s0, s1, s2};
    cols = '{cl, cm, cr};
    acc  = 0;
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 3; x++)
        acc += longint'($signed(kernel_reg[y][x*COEF_BITS +: COEF_BITS])) *
               longint'(window_pix[src[y]][cols[x]]);
    if (acc <= 0) begin
      q = 0;
    end else begin
      q   = acc >>> FRAC_BITS;
      rem = acc % (1 << FRAC_BITS);
      // Round half to even.
      if (rem > (1 << (FRAC_BITS - 1)) || (rem == (1 << (FRAC_BITS - 1)) && q % 2 == 1))
        q++;
      if (q > PIX_MAX) q = PIX_MAX;
    end
    res.pixel  = q[PIX_W-1:0];
    res.row    = row[CNT_W-1:0];
    res.column = col[CNT_W-1:0];
    res.done   = done;
    res.last   = 1'b0;
    return res;
  endfunction

  function automatic void conv_predict(pix_t p);
    int w;
    int h;
    int c;
    int r;
    int top;
    int lc;
    pix_t above;
    pix_t two_above;
    bit end_col;
    bit last_row;
    conv_result_t batch [$];
    conv_result_t res;
    w = clamp_dim(width_reg, WIDTH_CAP);
    h = clamp_dim(height_reg, FRAME_MAX);
    c = col_count;
    r = row_count;
    two_above = row_two_above_mem[c];
    above     = row_above_mem[c];
    row_two_above_mem[c] = above;
    row_above_mem[c]     = p;
    for (int i = 0; i < 3; i++) begin
      window_pix[i][0] = window_pix[i][1];
      window_pix[i][1] = window_pix[i][2];
      window_pix[i][2] = window_pix[i][3];
    end
    window_pix[0][3] = two_above;
    window_pix[1][3] = above;
    window_pix[2][3] = p;
    end_col  = (c >= w - 1);
    last_row = (r >= h - 1);
    if (r >= 1) begin
      // Row -1 mirrors to row 1, column -1 mirrors to column 1.
      top = (r == 1) ? 2 : 0;
      lc  = (c == 1) ? 3 : 1;
      if (c >= 1)
        batch.insert(batch.size(), window_result(top, 1, 2, lc, 2, 3, r - 1, c - 1, 1'b0));
      if (end_col)
        batch.insert(batch.size(), window_result(top, 1, 2, 2, 3, 2, r - 1, c, 1'b0));
      // The bottom row mirrors the row above it and is finished right here.
      if (last_row) begin
        if (c >= 1)
          batch.insert(batch.size(), window_result(1, 2, 1, lc, 2, 3, r, c - 1, 1'b0));
        if (end_col)
          batch.insert(batch.size(), window_result(1, 2, 1, 2, 3, 2, r, c, 1'b1));
      end
    end
    foreach (batch[i]) begin
      res      = batch[i];
      res.last = (i == batch.size() - 1);
      expected_conv.insert(expected_conv.size(), res);
    end
    if (end_col) begin
      col_count = 0;
      row_count = last_row ? 0 : (r + 1) % FRAME_MAX;
    end else begin
      col_count = (c + 1) % FRAME_MAX;
    end
  endfunction

  function automatic int fill_frame(pix_kind_t kind);
    int count;
    pix_t level;
    count = clamp_dim(width_reg, WIDTH_CAP) * clamp_dim(height_reg, FRAME_MAX);
    level = pix_t'($urandom_range(0, PIX_MAX));
    for (int i = 0; i < count; i++) begin
      case (kind)
        PIX_RANDOM:
          pending_pixels.insert(pending_pixels.size(), pix_t'($urandom_range(0, PIX_MAX)));
        PIX_EXTREME:
          pending_pixels.insert(pending_pixels.size(),
                                pix_t'($urandom_range(0, 1) ? PIX_MAX : 0));
        default:
          pending_pixels.insert(pending_pixels.size(), level);
      endcase
    end
    return count;
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [KREG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_WIDTH:   width_reg     = data[DIM_W-1:0];
      REG_FRAME_HEIGHT:  height_reg    = data[DIM_W-1:0];
      REG_KERNEL_TOP:    kernel_reg[0] = data;
      REG_KERNEL_MIDDLE: kernel_reg[1] = data;
      REG_KERNEL_BOTTOM: kernel_reg[2] = data;
      default: ;
    endcase
  endtask

  task automatic await_idle();
    while (pending_pixels.size() != 0 || in_valid || expected_conv.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : pixel_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) conv_predict(in_pixel_in);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          in_valid    <= 1'b1;
          in_pixel_in <= pending_pixels.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    conv_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_conv.size() == 0) begin
          $display("%0t: unexpected result item, pixel %0d row %0d column %0d", $time,
                   out_pixel_out, out_row, out_column);
          error_count++;
        end else begin
          want = expected_conv.pop_front();
          compare_field("pixel_out", want.pixel, out_pixel_out);
          compare_field("out_row", want.row, out_row);
          compare_field("out_column", want.column, out_column);
          compare_field("frame_done", want.done, out_frame_done);
          compare_field("run_last", want.last, out_run_last);
        end
      end
      // One long hold-off while the sender still has plenty queued, so the
      // core backs up into its input.
      if (!long_hold_done && pending_pixels.size() > LONG_HOLD_TRIGGER) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = rx_mode_t'($urandom_range(0, 3));
          mode_left  = $urandom_range(40, 300);
        end else begin
          mode_left--;
        end
        stall_phase = (stall_phase + 1) % 5;
        case (stall_mode)
          RX_OPEN:     out_ready <= 1'b1;
          RX_SPARSE:   out_ready <= ($urandom_range(0, 9) >= 3);
          RX_PERIODIC: out_ready <= (stall_phase < 3);
          default:     out_ready <= ($urandom_range(0, 9) >= 7);
        endcase
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin : stimulus
    int items_sent;
    int kind_pick;
    int w_raw;
    int h_raw;
    pix_kind_t kind;
    logic [KREG_W-1:0] data;
    logic [CFG_IDX_W-1:0] kernel_index [3];
    kernel_index = '{REG_KERNEL_TOP, REG_KERNEL_MIDDLE, REG_KERNEL_BOTTOM};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest frame through the identity kernel left by reset.
    cfg_write(REG_FRAME_WIDTH, KREG_W'(2));
    cfg_write(REG_FRAME_HEIGHT, KREG_W'(2));
    cfg_valid <= 1'b0;
    pending_pixels = '{8'd0, 8'd255, 8'd7, 8'd128};
    await_idle();

    // A half-weight center tap puts odd pixels exactly on a rounding tie.
    cfg_write(REG_FRAME_WIDTH, KREG_W'(3));
    cfg_write(REG_KERNEL_MIDDLE, tap_row(0, 128, 0));
    cfg_valid <= 1'b0;
    pending_pixels = '{8'd1, 8'd3, 8'd5, 8'd254, 8'd255, 8'd0};
    await_idle();

    // Dimensions below the minimum clamp to 2x2; the largest taps saturate.
    cfg_write(REG_FRAME_WIDTH, KREG_W'(0));
    cfg_write(REG_FRAME_HEIGHT, KREG_W'(1));
    foreach (kernel_index[k]) cfg_write(kernel_index[k], tap_row(2047, 2047, 2047));
    cfg_valid <= 1'b0;
    items_sent = fill_frame(PIX_EXTREME);
    await_idle();

    // The most negative taps clamp to zero; an unmapped index changes nothing.
    cfg_write(REG_FRAME_WIDTH, KREG_W'(3));
    cfg_write(REG_FRAME_HEIGHT, KREG_W'(3));
    foreach (kernel_index[k]) cfg_write(kernel_index[k], tap_row(-2048, -2048, -2048));
    cfg_write(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
              KREG_W'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
    items_sent = fill_frame(PIX_EXTREME);
    await_idle();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        w_raw = $urandom_range(0, 24);
        h_raw = $urandom_range(0, 10);
      end else begin
        w_raw = $urandom_range(2, 12);
        h_raw = $urandom_range(2, 8);
      end
      // Bits above the dimension field are don't-care; sometimes fill them.
      if ($urandom_range(0, 1)) begin
        data = KREG_W'({$urandom, $urandom});
        if ($urandom_range(0, 3) != 0) data[KREG_W-1:DIM_W] = '0;
        data[DIM_W-1:0] = DIM_W'(w_raw);
        cfg_write(REG_FRAME_WIDTH, data);
      end
      if ($urandom_range(0, 1)) begin
        data = KREG_W'({$urandom, $urandom});
        if ($urandom_range(0, 3) != 0) data[KREG_W-1:DIM_W] = '0;
        data[DIM_W-1:0] = DIM_W'(h_raw);
        cfg_write(REG_FRAME_HEIGHT, data);
      end
      foreach (kernel_index[k])
        if ($urandom_range(0, 1)) cfg_write(kernel_index[k], random_kernel_row());
      if ($urandom_range(0, 7) == 0)
        cfg_write(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
                  KREG_W'({$urandom, $urandom}));
      cfg_valid <= 1'b0;
      kind_pick = $urandom_range(0, 9);
      kind = (kind_pick < 7) ? PIX_RANDOM : ((kind_pick == 7) ? PIX_EXTREME : PIX_FLAT);
      items_sent += fill_frame(kind);
      await_idle();
    end

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
